// ===== rtl/bsc_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation block.
`default_nettype none
package bsc_pkg;

    localparam int DATA_W    = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS   = 2'd3;

    // Item kinds.
    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRES = 1'b1;

    // Compensation constants.
    localparam logic [DATA_W-1:0] B6_OFFSET = 32'd4000;
    localparam logic [DATA_W-1:0] B4_BIAS   = 32'd32768;
    localparam logic [DATA_W-1:0] B7_SCALE  = 32'd50000;
    localparam logic [DATA_W-1:0] P_COEF_A  = 32'd3038;
    localparam logic [DATA_W-1:0] P_COEF_B  = 32'hFFFF_E343;
    localparam logic [DATA_W-1:0] P_ROUND   = 32'd3791;
    localparam logic [DATA_W-1:0] T_ROUND   = 32'd8;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_SUB,
        S_T_MUL,
        S_T_DEN,
        S_T_CHK,
        S_T_DIV,
        S_T_SUM,
        S_T_RES,
        S_P_B6,
        S_P_SQ,
        S_P_AC2,
        S_P_B2,
        S_P_SUM,
        S_P_B3,
        S_P_X3,
        S_P_B4A,
        S_P_B7,
        S_P_CHK,
        S_P_DIV,
        S_P_PSQ,
        S_P_X1,
        S_P_X2,
        S_P_SUM2,
        S_P_RES,
        S_OUT
    } state_t;

    function automatic logic [DATA_W-1:0] sext16(input logic [15:0] v);
        return {{(DATA_W-16){v[15]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] zext16(input logic [15:0] v);
        return {{(DATA_W-16){1'b0}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v,
                                              input logic [4:0] s);
        return DATA_W'($signed(v) >>> s);
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(0) - v : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bsc_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module bsc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bsc_pkg::DATA_W-1:0] dividend,
    input  wire logic [bsc_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [bsc_pkg::DATA_W-1:0]     quotient
);
    import bsc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // A borrow means the divisor did not fit, so the bit is zero.
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
            end
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> divisor != '0)
        else $error("divider started with a zero divisor");
`endif

endmodule
`default_nettype wire

// ===== rtl/baro_sensor_compensation.sv =====
// Top level: barometric sensor compensation with one shared multiplier and divider.
// Sequencing: a temperature or pressure word runs through its sequencer states and the
// divider, whose wait dominates; a zero divisor skips the divider and yields an error word.
// Flow: one word in flight; in_ready is high only in the idle state, so a new word is
// taken only once the last result leaves S_OUT, which waits while out_valid && !out_ready.
// Reset clears the sequencer, output valid, calibration registers and the kept B5 term.
`default_nettype none
module baro_sensor_compensation (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                 cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        op,
    input  wire logic [18:0]                 raw_sample,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             kind,
    output logic signed [31:0]               value,
    output logic                             div_error
);
    import bsc_pkg::*;

    state_t            state_reg, state_next;

    logic [63:0]       cal_a_reg;
    logic [63:0]       cal_b_reg;
    logic [47:0]       cal_c_reg;
    logic [1:0]        oss_reg;
    logic [DATA_W-1:0] temp_term_reg, temp_term_next;

    logic              op_reg;
    logic [18:0]       raw_reg;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] b6_reg, b6_next;
    logic [DATA_W-1:0] sq_reg, sq_next;
    logic [DATA_W-1:0] b3_reg, b3_next;
    logic [DATA_W-1:0] rb_reg, rb_next;
    logic [DATA_W-1:0] b7_reg, b7_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_err_reg, res_err_next;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [DATA_W-1:0] value_reg;
    logic              err_reg;

    logic [DATA_W-1:0] mul_a, mul_b;
    logic              div_start;
    logic [DATA_W-1:0] div_dividend, div_divisor;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    logic [DATA_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [DATA_W-1:0] num_t, b4, p_scaled;
    logic              in_fire, out_free;

    assign ac1 = sext16(cal_a_reg[15:0]);
    assign ac2 = sext16(cal_a_reg[31:16]);
    assign ac3 = sext16(cal_a_reg[47:32]);
    assign ac4 = zext16(cal_a_reg[63:48]);
    assign ac5 = zext16(cal_b_reg[15:0]);
    assign ac6 = zext16(cal_b_reg[31:16]);
    assign b1  = sext16(cal_b_reg[47:32]);
    assign b2  = sext16(cal_b_reg[63:48]);
    assign mc  = sext16(cal_c_reg[31:16]);
    assign md  = sext16(cal_c_reg[47:32]);

    assign num_t    = mc << 11;
    assign b4       = prod_reg >> 15;
    assign p_scaled = asr(p_reg, 5'd8);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    bsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) state_next = (op == OP_TEMP) ? S_T_SUB : S_P_B6;
            S_T_SUB:  state_next = S_T_MUL;
            S_T_MUL:  state_next = S_T_DEN;
            S_T_DEN:  state_next = S_T_CHK;
            S_T_CHK:  state_next = (acc_reg == '0) ? S_OUT : S_T_DIV;
            S_T_DIV:  if (div_done) state_next = S_T_SUM;
            S_T_SUM:  state_next = S_T_RES;
            S_T_RES:  state_next = S_OUT;
            S_P_B6:   state_next = S_P_SQ;
            S_P_SQ:   state_next = S_P_AC2;
            S_P_AC2:  state_next = S_P_B2;
            S_P_B2:   state_next = S_P_SUM;
            S_P_SUM:  state_next = S_P_B3;
            S_P_B3:   state_next = S_P_X3;
            S_P_X3:   state_next = S_P_B4A;
            S_P_B4A:  state_next = S_P_B7;
            S_P_B7:   state_next = S_P_CHK;
            S_P_CHK:  state_next = (b4 == '0) ? S_OUT : S_P_DIV;
            S_P_DIV:  if (div_done) state_next = S_P_PSQ;
            S_P_PSQ:  state_next = S_P_X1;
            S_P_X1:   state_next = S_P_X2;
            S_P_X2:   state_next = S_P_SUM2;
            S_P_SUM2: state_next = S_P_RES;
            S_P_RES:  state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, divider start and datapath updates.
    always_comb
    begin
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        acc_next       = acc_reg;
        x_next         = x_reg;
        b6_next        = b6_reg;
        sq_next        = sq_reg;
        b3_next        = b3_reg;
        rb_next        = rb_reg;
        b7_next        = b7_reg;
        p_next         = p_reg;
        neg_next       = neg_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        temp_term_next = temp_term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_T_SUB:
            begin
                acc_next = zext16(raw_reg[15:0]) - ac6;
            end
            S_T_MUL:
            begin
                mul_a = acc_reg;
                mul_b = ac5;
            end
            S_T_DEN:
            begin
                x_next   = asr(prod_reg, 5'd15);
                acc_next = asr(prod_reg, 5'd15) + md;
            end
            S_T_CHK:
            begin
                if (acc_reg == '0)
                begin
                    res_value_next = '0;
                    res_err_next   = 1'b1;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = mag(num_t);
                    div_divisor  = mag(acc_reg);
                    neg_next     = num_t[DATA_W-1] ^ acc_reg[DATA_W-1];
                end
            end
            S_T_DIV:
            begin
                if (div_done)
                begin
                    acc_next = neg_reg ? DATA_W'(0) - div_quotient : div_quotient;
                end
            end
            S_T_SUM:
            begin
                temp_term_next = x_reg + acc_reg;
            end
            S_T_RES:
            begin
                res_value_next = asr(temp_term_reg + T_ROUND, 5'd4);
                res_err_next   = 1'b0;
            end
            S_P_B6:
            begin
                b6_next = temp_term_reg - B6_OFFSET;
            end
            S_P_SQ:
            begin
                mul_a = b6_reg;
                mul_b = b6_reg;
            end
            S_P_AC2:
            begin
                sq_next = asr(prod_reg, 5'd12);
                mul_a   = ac2;
                mul_b   = b6_reg;
            end
            S_P_B2:
            begin
                acc_next = asr(prod_reg, 5'd11);
                mul_a    = b2;
                mul_b    = sq_reg;
            end
            S_P_SUM:
            begin
                acc_next = asr(prod_reg, 5'd11) + acc_reg + (ac1 << 2);
                mul_a    = ac3;
                mul_b    = b6_reg;
            end
            S_P_B3:
            begin
                b3_next  = asr((acc_reg << oss_reg) + 32'd2, 5'd2);
                acc_next = asr(prod_reg, 5'd13);
                mul_a    = b1;
                mul_b    = sq_reg;
            end
            S_P_X3:
            begin
                acc_next = asr(acc_reg + asr(prod_reg, 5'd16) + 32'd2, 5'd2);
                rb_next  = {{(DATA_W-19){1'b0}}, raw_reg} - b3_reg;
            end
            S_P_B4A:
            begin
                acc_next = acc_reg + B4_BIAS;
                mul_a    = rb_reg;
                mul_b    = B7_SCALE >> oss_reg;
            end
            S_P_B7:
            begin
                b7_next = prod_reg;
                mul_a   = ac4;
                mul_b   = acc_reg;
            end
            S_P_CHK:
            begin
                if (b4 == '0)
                begin
                    res_value_next = '0;
                    res_err_next   = 1'b1;
                end
                else
                begin
                    // A large B7 is divided first and doubled after, as 32 bits allow.
                    div_start    = 1'b1;
                    div_dividend = b7_reg[DATA_W-1] ? b7_reg : b7_reg << 1;
                    div_divisor  = b4;
                    neg_next     = b7_reg[DATA_W-1];
                end
            end
            S_P_DIV:
            begin
                if (div_done)
                begin
                    p_next = neg_reg ? div_quotient << 1 : div_quotient;
                end
            end
            S_P_PSQ:
            begin
                mul_a = p_scaled;
                mul_b = p_scaled;
            end
            S_P_X1:
            begin
                mul_a = prod_reg;
                mul_b = P_COEF_A;
            end
            S_P_X2:
            begin
                acc_next = asr(prod_reg, 5'd16);
                mul_a    = P_COEF_B;
                mul_b    = p_reg;
            end
            S_P_SUM2:
            begin
                acc_next = asr(acc_reg + asr(prod_reg, 5'd16) + P_ROUND, 5'd4);
            end
            S_P_RES:
            begin
                res_value_next = p_reg + acc_reg;
                res_err_next   = 1'b0;
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign prod_next = DATA_W'(mul_a * mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            temp_term_reg <= '0;
            cal_a_reg     <= '0;
            cal_b_reg     <= '0;
            cal_c_reg     <= '0;
            oss_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            temp_term_reg <= temp_term_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CAL_A: cal_a_reg <= cfg_data;
                    CFG_CAL_B: cal_b_reg <= cfg_data;
                    CFG_CAL_C: cal_c_reg <= cfg_data[47:0];
                    CFG_OSS:   oss_reg   <= cfg_data[1:0];
                    default:   oss_reg   <= oss_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op;
            raw_reg <= raw_sample;
        end
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        x_reg         <= x_next;
        b6_reg        <= b6_next;
        sq_reg        <= sq_next;
        b3_reg        <= b3_next;
        rb_reg        <= rb_next;
        b7_reg        <= b7_next;
        p_reg         <= p_next;
        neg_reg       <= neg_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        if (state_reg == S_OUT && out_free)
        begin
            kind_reg  <= op_reg;
            value_reg <= res_value_reg;
            err_reg   <= res_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = $signed(value_reg);
    assign div_error = err_reg;

`ifndef ASSERT_OFF
    a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == S_T_CHK || state_reg == S_P_CHK))
        else $error("divider started outside a check step");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_T_DIV || state_reg == S_P_DIV))
        else $error("division finished while the sequencer was not waiting");
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("accepted word did not start the sequencer");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> value_reg == '0)
        else $error("division error word carries a nonzero value");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the barometric compensation block: directed and random words checked by a built-in predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 175;

    // Typical factory calibration of the sensor family.
    localparam logic [63:0] DS_CAL_A = {16'h7FE5, 16'hC7D1, 16'hFFB8, 16'h0198};
    localparam logic [63:0] DS_CAL_B = {16'h0004, 16'h182E, 16'h5A71, 16'h7FF5};
    localparam logic [63:0] DS_CAL_C = {16'h0000, 16'h0B34, 16'hDDF9, 16'h8000};

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        div_error;
    } reading_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 in_op     = 1'b0;
    logic [18:0]          in_raw    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind_out;
    logic signed [31:0]   value_out;
    logic                 div_error_out;

    // Predictor copy of the registers and the kept B5 term.
    logic [63:0] model_cal_a = '0;
    logic [63:0] model_cal_b = '0;
    logic [47:0] model_cal_c = '0;
    logic [1:0]  model_oss   = '0;
    logic [31:0] kept_b5     = '0;

    reading_t pending_readings[$];
    reading_t head_reading;
    int       error_count = 0;
    int       cycle_count = 0;
    logic     idle_on     = 1'b1;
    logic     hold_req    = 1'b0;
    logic     out_hold    = 1'b0;
    int       hold_left   = 0;
    int       sink_gap    = 0;

    baro_sensor_compensation dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (in_op),
        .raw_sample (in_raw),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind_out),
        .value      (value_out),
        .div_error  (div_error_out)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] shr_arith(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] t;
        t = v;
        return t >>> s;
    endfunction

    function automatic logic [31:0] lane_signed(input logic [63:0] w, input int unsigned pos);
        logic [15:0] f;
        f = w[pos +: 16];
        return {{16{f[15]}}, f};
    endfunction

    function automatic logic [31:0] lane_unsigned(input logic [63:0] w, input int unsigned pos);
        return {16'd0, w[pos +: 16]};
    endfunction

    // Signed division truncating toward zero, done on magnitudes so that
    // the most negative numerator wraps the same way as on a 32-bit target.
    function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
        logic [31:0] un;
        logic [31:0] ud;
        logic [31:0] q;
        un = n[31] ? 32'd0 - n : n;
        ud = d[31] ? 32'd0 - d : d;
        q  = un / ud;
        return (n[31] != d[31]) ? 32'd0 - q : q;
    endfunction

    function automatic logic [63:0] jitter_lanes(input logic [63:0] w);
        logic [63:0] r;
        for (int i = 0; i < 4; i++)
            r[16*i +: 16] = w[16*i +: 16] + 16'($urandom_range(0, 511)) - 16'd256;
        return r;
    endfunction

    function automatic logic [18:0] pick_temp_raw();
        if ($urandom_range(0, 1) == 0)
            return 19'($urandom_range(15000, 40000));
        return 19'($urandom);
    endfunction

    function automatic logic [18:0] pick_pres_raw(input logic [1:0] oss_v);
        if ($urandom_range(0, 2) == 0)
            return 19'($urandom);
        return 19'($urandom_range(15000, 45000)) << oss_v;
    endfunction

    // Computes the expected reading of one accepted word; a temperature word with a nonzero divisor sets B5.
    task automatic predict_reading(input logic op_v, input logic [18:0] raw_v);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, x1, x2, x3, den, num, b6, sq, b3, b4, b7, p;
        reading_t    r;
        ac1 = lane_signed(model_cal_a, 0);
        ac2 = lane_signed(model_cal_a, 16);
        ac3 = lane_signed(model_cal_a, 32);
        ac4 = lane_unsigned(model_cal_a, 48);
        ac5 = lane_unsigned(model_cal_b, 0);
        ac6 = lane_unsigned(model_cal_b, 16);
        b1  = lane_signed(model_cal_b, 32);
        b2  = lane_signed(model_cal_b, 48);
        mc  = lane_signed({16'd0, model_cal_c}, 16);
        md  = lane_signed({16'd0, model_cal_c}, 32);
        r.kind      = op_v;
        r.value     = '0;
        r.div_error = 1'b0;
        if (op_v == OP_TEMP) begin
            ut  = {16'd0, raw_v[15:0]};
            x1  = shr_arith((ut - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 32'd0) begin
                r.div_error = 1'b1;
            end else begin
                num     = mc << 11;
                x2      = div_trunc(num, den);
                kept_b5 = x1 + x2;
                r.value = shr_arith(kept_b5 + T_ROUND, 4);
            end
        end else begin
            b6 = kept_b5 - B6_OFFSET;
            sq = shr_arith(b6 * b6, 12);
            x1 = shr_arith(b2 * sq, 11);
            x2 = shr_arith(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = shr_arith(((ac1 * 32'd4 + x3) << model_oss) + 32'd2, 2);
            x1 = shr_arith(ac3 * b6, 13);
            x2 = shr_arith(b1 * sq, 16);
            x3 = shr_arith(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
            b7 = ({13'd0, raw_v} - b3) * (B7_SCALE >> model_oss);
            if (b4 == 32'd0) begin
                r.div_error = 1'b1;
            end else begin
                if (b7 < 32'h8000_0000)
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = shr_arith(p, 8);
                x1 = x1 * x1;
                x1 = shr_arith(x1 * P_COEF_A, 16);
                x2 = shr_arith(P_COEF_B * p, 16);
                p  = p + shr_arith(x1 + x2 + P_ROUND, 4);
                r.value = p;
            end
        end
        pending_readings.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s, got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_word(input logic op_v, input logic [18:0] raw_v);
        int gap;
        in_valid <= 1'b1;
        in_op    <= op_v;
        in_raw   <= raw_v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_reading(op_v, raw_v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering words and waits until every expected reading is back.
    task automatic drain_readings();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CAL_A: model_cal_a = data;
            CFG_CAL_B: model_cal_b = data;
            CFG_CAL_C: model_cal_c = data[47:0];
            CFG_OSS:   model_oss   = data[1:0];
            default:   ;
        endcase
    endtask

    task automatic load_calibration(input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] c, input logic [63:0] oss_data);
        drain_readings();
        write_register(CFG_CAL_A, a);
        write_register(CFG_CAL_B, b);
        write_register(CFG_CAL_C, c);
        write_register(CFG_OSS, oss_data);
        cfg_valid <= 1'b0;
    endtask

    // With every register at zero both divisors are zero.
    task automatic test_reset_defaults();
        send_word(OP_TEMP, 19'd27898);
        send_word(OP_PRES, 19'd23843);
    endtask

    task automatic test_datasheet_example();
        load_calibration(DS_CAL_A, DS_CAL_B, DS_CAL_C, 64'd0);
        // B5 is still zero here, so this pressure word uses the reset term.
        send_word(OP_PRES, 19'd23843);
        send_word(OP_TEMP, 19'd27898);
        send_word(OP_PRES, 19'd23843);
        send_word(OP_TEMP, 19'd0);
        send_word(OP_TEMP, 19'h0FFFF);
        send_word(OP_TEMP, 19'h7FFFF);
        send_word(OP_PRES, 19'd0);
        send_word(OP_PRES, 19'h7FFFF);
    endtask

    task automatic test_zero_divisors();
        // ac5 = 0x8000 and ac6 = 0 make x1 equal the raw value; md = -200.
        load_calibration(DS_CAL_A, {DS_CAL_B[63:32], 16'h0000, 16'h8000},
                         {16'h0000, 16'hFF38, DS_CAL_C[31:0]}, 64'd1);
        send_word(OP_TEMP, 19'd27898);
        send_word(OP_TEMP, 19'd200);
        send_word(OP_PRES, 19'd47000);
        load_calibration({16'h0000, DS_CAL_A[47:0]}, DS_CAL_B, DS_CAL_C, 64'd1);
        send_word(OP_PRES, 19'd47000);
        send_word(OP_TEMP, 19'd25000);
    endtask

    task automatic test_oversampling_extremes();
        for (int s = 0; s < 4; s++) begin
            load_calibration(DS_CAL_A, DS_CAL_B, DS_CAL_C, 64'(s));
            send_word(OP_TEMP, 19'd27898);
            send_word(OP_PRES, 19'd23843 << s);
        end
    endtask

    task automatic test_random_calibration();
        int          n;
        logic [63:0] a, b, c;
        logic [63:0] oss_data;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: begin
                    a = jitter_lanes(DS_CAL_A);
                    b = jitter_lanes(DS_CAL_B);
                    c = jitter_lanes(DS_CAL_C);
                end
                1: begin
                    a = {$urandom, $urandom};
                    b = {$urandom, $urandom};
                    c = {$urandom, $urandom};
                end
                default: begin
                    a = DS_CAL_A;
                    b = DS_CAL_B;
                    c = DS_CAL_C;
                end
            endcase
            if (phase == 0)
                oss_data = 64'd0;
            else if (phase == 1)
                oss_data = 64'd3;
            else
                oss_data = {$urandom, $urandom};
            load_calibration(a, b, c, oss_data);
            n = 0;
            while (n < PHASE_WORDS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_word(OP_TEMP, pick_temp_raw());
                        n += 1;
                    end
                    1, 2: begin
                        send_word(OP_PRES, pick_pres_raw(model_oss));
                        n += 1;
                    end
                    default: begin
                        send_word(OP_TEMP, pick_temp_raw());
                        send_word(OP_PRES, pick_pres_raw(model_oss));
                        n += 2;
                    end
                endcase
            end
        end
    endtask

    // The sink holds off for a long stretch so the block fills and stalls its input.
    task automatic test_output_backpressure();
        load_calibration(DS_CAL_A, DS_CAL_B, DS_CAL_C, 64'd2);
        hold_req <= 1'b1;
        send_word(OP_TEMP, pick_temp_raw());
        hold_req <= 1'b0;
        for (int i = 0; i < 39; i++)
            send_word(i[0] ? OP_TEMP : OP_PRES, i[0] ? pick_temp_raw() : pick_pres_raw(model_oss));
    endtask

    task automatic test_steady_stream();
        load_calibration(jitter_lanes(DS_CAL_A), jitter_lanes(DS_CAL_B),
                         jitter_lanes(DS_CAL_C), 64'd1);
        idle_on <= 1'b0;
        for (int i = 0; i < 100; i++) begin
            send_word(OP_TEMP, pick_temp_raw());
            send_word(OP_PRES, pick_pres_raw(model_oss));
        end
    endtask

    always @(posedge clk) begin
        if (out_hold) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                out_hold <= 1'b0;
        end else if (hold_req) begin
            out_hold  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk) begin
        if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
            sink_gap = $urandom_range(1, 6);
        out_ready <= (sink_gap == 0) && !out_hold;
        if (sink_gap > 0)
            sink_gap = sink_gap - 1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("word with no reading expected", value_out, 32'd0);
            end else begin
                head_reading = pending_readings.pop_front();
                if (kind_out !== head_reading.kind)
                    report_mismatch("kind", 32'(kind_out), 32'(head_reading.kind));
                if (value_out !== head_reading.value)
                    report_mismatch("value", value_out, head_reading.value);
                if (div_error_out !== head_reading.div_error)
                    report_mismatch("div_error", 32'(div_error_out), 32'(head_reading.div_error));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_datasheet_example();
        test_zero_divisors();
        test_oversampling_extremes();
        test_random_calibration();
        test_output_backpressure();
        test_steady_stream();
        drain_readings();
        repeat (64) @(posedge clk);
        if (pending_readings.size() != 0)
            report_mismatch("readings never returned", pending_readings.size(), 32'd0);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
